// ===== src/sws_pkg.sv =====
package sws_pkg;

  localparam int unsigned SWS_WINDOW      = 16;
  localparam int unsigned SWS_SAMPLE_BITS = 10;

  localparam int unsigned SPREAD_BITS = 10;
  localparam int unsigned SCALE_BITS  = 20;
  localparam int unsigned PADDR_BITS  = 3;
  localparam int unsigned PDATA_BITS  = 32;

  localparam logic [SPREAD_BITS-1:0] SPREAD_RESET = 10'd2;
  localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 20'd80000;

  typedef enum logic {
    REG_SPREAD_LIMIT = 1'b0,
    REG_FULL_SCALE   = 1'b1
  } reg_sel_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic scale_busy;
    logic scan_busy;
  } unit_status_t;

endpackage

// ===== src/sws_if.sv =====
interface sws_sample_if import sws_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SWS_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface sws_result_if import sws_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [SCALE_BITS-1:0] scaled_weight;
  logic                  is_stable;

  modport source (output valid, output scaled_weight, output is_stable, input ready);
  modport sink (input valid, input scaled_weight, input is_stable, output ready);
endinterface

// ===== src/sws_ram.sv =====
module sws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sws_scale.sv =====
module sws_scale import sws_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SWS_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SCALE_BITS-1:0]  full_scale,
  output logic                   busy,
  output logic [SCALE_BITS-1:0]  weight
);

  localparam int unsigned PROD_BITS = SAMPLE_BITS + SCALE_BITS;
  localparam int unsigned PASSES    = SCALE_BITS / SAMPLE_BITS + 3;
  localparam int unsigned CNT_BITS  = $clog2(PASSES + 1);
  localparam logic [SAMPLE_BITS-1:0] TOP  = {SAMPLE_BITS{1'b1}};
  localparam logic [PROD_BITS-1:0]   HALF = PROD_BITS'(TOP >> 1);

  logic                   mul_phase;
  logic                   load_phase;
  logic [CNT_BITS-1:0]    cnt;
  logic [PROD_BITS-1:0]   product;
  logic [PROD_BITS-1:0]   acc;
  logic [SCALE_BITS-1:0]  quo;
  logic [SCALE_BITS-1:0]  upper;
  logic [PROD_BITS-1:0]   folded;
  logic                   exact;

  // The divisor is 2^SAMPLE_BITS - 1, so a residue a * 2^SAMPLE_BITS + b equals
  // a * TOP + (a + b). Each pass adds a to the quotient and folds the residue
  // down; once it is no larger than TOP, a residue equal to TOP adds one more.
  always_comb begin
    upper  = acc[PROD_BITS-1:SAMPLE_BITS];
    folded = PROD_BITS'(upper) + PROD_BITS'(acc[SAMPLE_BITS-1:0]);
    exact  = (acc == PROD_BITS'(TOP));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_phase  <= 1'b0;
      load_phase <= 1'b0;
      cnt        <= '0;
    end else begin
      mul_phase  <= start;
      load_phase <= mul_phase;
      if (load_phase) begin
        cnt <= CNT_BITS'(PASSES);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      product <= PROD_BITS'(sample) * PROD_BITS'(full_scale);
    end
    if (load_phase) begin
      acc <= product + HALF;
      quo <= '0;
    end else if (cnt != '0) begin
      acc <= folded;
      quo <= quo + upper;
    end
  end

  assign busy   = mul_phase | load_phase | (cnt != '0);
  assign weight = quo + SCALE_BITS'(exact);

endmodule

// ===== src/sws_scan.sv =====
module sws_scan import sws_pkg::*; #(
  parameter int unsigned WINDOW      = SWS_WINDOW,
  parameter int unsigned SAMPLE_BITS = SWS_SAMPLE_BITS,
  localparam int unsigned AW = $clog2(WINDOW)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   full,
  input  logic [SPREAD_BITS-1:0] spread_limit,
  output logic [AW-1:0]          rd_addr,
  input  logic [SAMPLE_BITS-1:0] rd_data,
  output logic                   busy,
  output logic                   stable
);

  localparam int unsigned CMP_BITS =
    (SAMPLE_BITS > SPREAD_BITS) ? SAMPLE_BITS : SPREAD_BITS;
  localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

  logic                   issuing;
  logic                   rd_vld;
  logic                   rd_last;
  logic                   finish;
  logic [AW-1:0]          addr;
  logic [SAMPLE_BITS-1:0] lo;
  logic [SAMPLE_BITS-1:0] hi;
  logic [SAMPLE_BITS-1:0] spread;
  logic                   stable_r;

  assign spread = SAMPLE_BITS'(hi - lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
      finish  <= 1'b0;
    end else begin
      if (start) begin
        issuing <= full;
      end else if (issuing && (addr == LAST)) begin
        issuing <= 1'b0;
      end
      rd_vld  <= issuing;
      rd_last <= issuing && (addr == LAST);
      finish  <= rd_vld && rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr <= '0;
      lo   <= '1;
      hi   <= '0;
    end else begin
      if (issuing) begin
        addr <= addr + AW'(1);
      end
      if (rd_vld) begin
        if (rd_data < lo) begin
          lo <= rd_data;
        end
        if (rd_data > hi) begin
          hi <= rd_data;
        end
      end
    end
    if (start && !full) begin
      stable_r <= 1'b0;
    end else if (finish) begin
      stable_r <= (CMP_BITS'(spread) <= CMP_BITS'(spread_limit));
    end
  end

  assign rd_addr = addr;
  assign busy    = issuing | rd_vld | finish;
  assign stable  = stable_r;

endmodule

// ===== src/scale_weight_and_stability.sv =====
// Load-cell weight scaling with a window stability flag.
//
// Samples arrive on sample_in and results leave on result_out, both with a
// valid/ready handshake; one transfer in gives exactly one transfer out.
// The weight is (raw_sample * full_scale_kg + half) / full-scale sample,
// rounded, and is_stable is set once the window has been filled and the
// spread of the last WINDOW samples is within spread_limit.
// Each sample is written to the window RAM when it is accepted. A result is
// loaded into the output register once the divider has run its PASSES =
// SCALE_BITS / SAMPLE_BITS + 3 folding passes and the RAM scan is done; the
// next sample is taken only after that load, so one sample is in flight
// at a time. The one-entry-per-cycle RAM scan is the longer of the two
// except for tiny windows. If the receiver stalls, the result waits in
// the output register while the next sample is processed; that sample's
// result then waits for it. Synchronous reset empties the window, restores
// the register defaults and drops result_out.valid; the block accepts a
// sample right after. The user is to write the APB registers only while no
// sample is in flight; the block itself does not enforce this.
module scale_weight_and_stability import sws_pkg::*; #(
  parameter int unsigned WINDOW      = SWS_WINDOW,
  parameter int unsigned SAMPLE_BITS = SWS_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  sws_sample_if.sink            sample_in,
  sws_result_if.source          result_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW = $clog2(WINDOW);
  localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

  state_t                 state;
  state_t                 state_next;
  logic [SPREAD_BITS-1:0] spread_limit;
  logic [SCALE_BITS-1:0]  full_scale_kg;
  logic [AW-1:0]          write_slot;
  logic                   window_full;
  logic                   out_valid;
  logic [SCALE_BITS-1:0]  out_weight;
  logic                   out_stable;

  logic                   ready_in;
  logic                   in_fire;
  logic                   load_out;
  logic                   slot_wrap;
  logic                   full_after;
  logic                   cfg_write;
  reg_sel_t               cfg_sel;
  unit_status_t           status;
  logic [AW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SCALE_BITS-1:0]  weight;
  logic                   stable;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = reg_sel_t'(paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      REG_SPREAD_LIMIT: prdata = PDATA_BITS'(spread_limit);
      REG_FULL_SCALE:   prdata = PDATA_BITS'(full_scale_kg);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spread_limit  <= SPREAD_RESET;
      full_scale_kg <= SCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_SPREAD_LIMIT: spread_limit  <= pwdata[SPREAD_BITS-1:0];
        REG_FULL_SCALE:   full_scale_kg <= pwdata[SCALE_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    ready_in = (state == ST_IDLE);
    load_out = (state == ST_RUN) && !status.scale_busy && !status.scan_busy &&
               (!out_valid || result_out.ready);
  end

  assign in_fire         = sample_in.valid && ready_in;
  assign sample_in.ready = ready_in;
  assign slot_wrap       = (write_slot == LAST);
  assign full_after      = window_full || slot_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_slot  <= '0;
      window_full <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        write_slot <= slot_wrap ? '0 : write_slot + AW'(1);
        if (slot_wrap) begin
          window_full <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_weight <= weight;
      out_stable <= stable;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.scaled_weight = out_weight;
  assign result_out.is_stable     = out_stable;

  sws_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (in_fire),
    .waddr (write_slot),
    .wdata (sample_in.raw_sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sws_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .start      (in_fire),
    .sample     (sample_in.raw_sample),
    .full_scale (full_scale_kg),
    .busy       (status.scale_busy),
    .weight     (weight)
  );

  sws_scan #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (in_fire),
    .full         (full_after),
    .spread_limit (spread_limit),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .busy         (status.scan_busy),
    .stable       (stable)
  );

endmodule

// ===== src/sws_checker.sv =====
module sws_checker import sws_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [SCALE_BITS-1:0] out_weight,
  input logic                  out_stable
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_weight) && $stable(out_stable))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while another is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after a sample transfer");

  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("block not ready when a result was loaded");

endmodule

bind scale_weight_and_stability sws_checker u_sws_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample_in.valid),
  .in_ready   (sample_in.ready),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .out_weight (result_out.scaled_weight),
  .out_stable (result_out.is_stable)
);

// ===== tb/sv/scale_weight_and_stability_tb.sv =====
module scale_weight_and_stability_tb;
  import sws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_MAX    = (1 << SWS_SAMPLE_BITS) - 1;
  localparam int SPREAD_MAX    = (1 << SPREAD_BITS) - 1;
  localparam int SCALE_MAX     = 1000000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [SCALE_BITS-1:0] weight;
    logic                  stable;
  } reading_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    reg_sel_t              sel;
    logic [31:0]           value;
    logic                  typed;
    logic [SCALE_BITS-1:0] weight;
    logic                  stable;
  } step_t;

  localparam step_t DIRECTED [25] = '{
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd0,       1'b1, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd1023,    1'b1, 20'd80000,   1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd341,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd682,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd512,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd511,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd700,     1'b0, 20'd0,       1'b0},
    '{ROW_WRITE,  REG_FULL_SCALE,   32'd0,       1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd1023,    1'b1, 20'd0,       1'b0},
    '{ROW_WRITE,  REG_SPREAD_LIMIT, 32'd1023,    1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd5,       1'b1, 20'd0,       1'b1},
    '{ROW_WRITE,  REG_FULL_SCALE,   32'd1000000, 1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd1023,    1'b1, 20'd1000000, 1'b1},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd0,       1'b1, 20'd0,       1'b1},
    '{ROW_WRITE,  REG_SPREAD_LIMIT, 32'd0,       1'b0, 20'd0,       1'b0},
    '{ROW_SAMPLE, REG_SPREAD_LIMIT, 32'd1023,    1'b1, 20'd1000000, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  sws_sample_if smp ();
  sws_result_if res ();

  scale_weight_and_stability u_top (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (smp),
    .result_out (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  logic [SWS_SAMPLE_BITS-1:0] window_model [SWS_WINDOW];
  int                         next_slot;
  bit                         window_filled;
  logic [SPREAD_BITS-1:0]     spread_limit_q;
  logic [SCALE_BITS-1:0]      full_scale_q;

  reading_t expected_readings [$];
  reading_t want;
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_req = 0;
  int       hold_left = 0;
  int       run_left = 0;
  int       run_base = 0;
  int       run_jitter = 0;

  always #1 clk = ~clk;

  function automatic reading_t predict_reading(input logic [SWS_SAMPLE_BITS-1:0] s);
    logic [SWS_SAMPLE_BITS-1:0] lo;
    logic [SWS_SAMPLE_BITS-1:0] hi;
    bit [63:0]                  scaled;
    reading_t                   r;
    int                         k;
    window_model[next_slot] = s;
    if (next_slot == SWS_WINDOW - 1) begin
      next_slot = 0;
      window_filled = 1'b1;
    end else begin
      next_slot++;
    end
    scaled = 64'(s) * 64'(full_scale_q) + 64'(SAMPLE_MAX / 2);
    r.weight = SCALE_BITS'(scaled / 64'(SAMPLE_MAX));
    lo = '1;
    hi = '0;
    for (k = 0; k < SWS_WINDOW; k++) begin
      if (window_model[k] < lo) lo = window_model[k];
      if (window_model[k] > hi) hi = window_model[k];
    end
    r.stable = window_filled && ((hi - lo) <= spread_limit_q);
    return r;
  endfunction

  // Mostly runs of near-identical samples so the window can settle, with bursts of noise.
  function automatic logic [SWS_SAMPLE_BITS-1:0] next_sample();
    if (run_left == 0) begin
      if ($urandom_range(0, 99) < 80) begin
        run_jitter = $urandom_range(0, 3);
        run_left = $urandom_range(16, 48);
      end else begin
        run_jitter = SAMPLE_MAX;
        run_left = $urandom_range(1, 8);
      end
      run_base = $urandom_range(0, SAMPLE_MAX - run_jitter);
    end
    run_left--;
    if ($urandom_range(0, 99) < 3) return SWS_SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    return SWS_SAMPLE_BITS'(run_base + $urandom_range(0, run_jitter));
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 59;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 59;
      end
      default: begin
        send_idle_pct = 23;
        recv_stall_pct = 23;
      end
    endcase
  endtask

  task automatic put_sample(input logic [SWS_SAMPLE_BITS-1:0] s, input logic typed,
                            input logic [SCALE_BITS-1:0] weight, input logic stable);
    reading_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.raw_sample <= s;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    r = predict_reading(s);
    if (typed) begin
      r.weight = weight;
      r.stable = stable;
    end
    expected_readings.push_back(r);
  endtask

  task automatic drain(input int settle);
    smp.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input reg_sel_t sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_SPREAD_LIMIT) begin
      spread_limit_q = value[SPREAD_BITS-1:0];
    end else begin
      full_scale_q = value[SCALE_BITS-1:0];
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result: weight %0d stable %0d", $time,
                   res.scaled_weight, res.is_stable);
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          if (res.scaled_weight !== want.weight) begin
            $display("%0t: scaled_weight mismatch: expected %0d actual %0d", $time,
                     want.weight, res.scaled_weight);
            mismatch_count++;
          end
          if (res.is_stable !== want.stable) begin
            $display("%0t: is_stable mismatch: expected %0d actual %0d", $time,
                     want.stable, res.is_stable);
            mismatch_count++;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    smp.valid <= 1'b0;
    smp.raw_sample <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    next_slot = 0;
    window_filled = 1'b0;
    spread_limit_q = SPREAD_RESET;
    full_scale_q = SCALE_RESET;
    foreach (window_model[k]) window_model[k] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        drain(4);
        write_reg(DIRECTED[i].sel, DIRECTED[i].value);
      end else begin
        put_sample(DIRECTED[i].value[SWS_SAMPLE_BITS-1:0], DIRECTED[i].typed,
                   DIRECTED[i].weight, DIRECTED[i].stable);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain(4);
      case (p)
        0: begin
          write_reg(REG_SPREAD_LIMIT, 32'd0);
          write_reg(REG_FULL_SCALE, $urandom_range(0, SCALE_MAX));
        end
        1: begin
          write_reg(REG_SPREAD_LIMIT, SPREAD_MAX);
          write_reg(REG_FULL_SCALE, SCALE_MAX);
        end
        2: begin
          write_reg(REG_SPREAD_LIMIT, $urandom_range(0, 3));
          write_reg(REG_FULL_SCALE, 32'd0);
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_SPREAD_LIMIT, $urandom_range(0, 7));
          end else begin
            write_reg(REG_SPREAD_LIMIT, $urandom_range(0, SPREAD_MAX));
          end
          write_reg(REG_FULL_SCALE, $urandom_range(0, SCALE_MAX));
        end
      endcase
      set_idling(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == 60) hold_req = HOLD_CYCLES;
        if (p == 6 && n == 100) drain(0);
        put_sample(next_sample(), 1'b0, '0, 1'b0);
      end
    end

    drain(SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sws_pkg.sv
src/sws_if.sv
src/sws_ram.sv
src/sws_scale.sv
src/sws_scan.sv
src/scale_weight_and_stability.sv
src/sws_checker.sv
tb/sv/scale_weight_and_stability_tb.sv
